// ===== src/ctdh_pkg.sv =====
`timescale 1ns / 1ps

package ctdh_pkg;

    // Request kinds carried on the slave-side tuser.
    localparam logic [1:0] CMD_LOAD_MAP = 2'd0;
    localparam logic [1:0] CMD_HIT      = 2'd1;
    localparam logic [1:0] CMD_READ_BIN = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_WINDOW  = 2'd0;
    localparam logic [1:0] REG_LOW_CH  = 2'd1;
    localparam logic [1:0] REG_HIGH_CH = 2'd2;

    // Configuration reset values.
    localparam logic [13:0] WINDOW_RESET  = 14'd16383;
    localparam logic [11:0] LOW_CH_RESET  = 12'd0;
    localparam logic [11:0] HIGH_CH_RESET = 12'd1023;

    // Largest value of the pair count in one result.
    localparam logic [4:0] PAIRS_MAX = 5'd31;

    // One channel map entry.
    typedef struct packed {
        logic [4:0] pos;
        logic [1:0] col;
        logic [3:0] seg;
    } map_entry_t;

    // One buffered hit; the valid bits are kept apart in flip-flops.
    typedef struct packed {
        logic        is_cc;
        logic [4:0]  pos;
        logic [1:0]  col;
        logic [47:0] hit_time;
    } ring_entry_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MAP_RD,
        ST_MAP_CHK,
        ST_SCAN,
        ST_INC,
        ST_UPDATE,
        ST_BIN_RD,
        ST_BIN_CAP,
        ST_FINISH
    } state_t;

endpackage

// ===== src/coincidence_time_difference_histogram_unit.sv =====
`timescale 1ns / 1ps
// Coincidence time-difference histogram unit.
// Requests enter on the s_ channel, kind on s_tuser: load a channel map entry,
// present a hit event, or read one histogram bin. Every request gives exactly
// one result on the m_ channel (bin count, pairs added, sticky bad-trigger
// flag, ring overflow flag). Registers are to be written on the cfg_ port only while idle.
// A hit event reads its channel map entry and, for a valid channel, walks the ring
// of recent hits and then buffers the hit, latches the error, or does neither; a hit on an
// invalid channel skips the walk, and a hit while the error is latched goes
// straight to its result.
// Each result appears on m_tvalid together with s_tready.
// A hit walks the ring of recent hits one entry per cycle through one shared
// time-difference compare, and each match holds the walk for the read-modify-write
// of the histogram memory, which has one write port and one registered read port.
// After reset the histogram is swept to zero, one bin per cycle, and s_tready
// stays low during the sweep. Ring entries start invalid and the error flag clear;
// register writes are taken at any time. The result sits in an output register,
// so the next request is accepted while the receiver stalls; the unit then waits
// at the end of that request until the output register is free.

module coincidence_time_difference_histogram_unit #(
    parameter int NUM_POSITIONS = 17,
    parameter int NUM_SEGMENTS  = 9,
    parameter int MAP_DEPTH     = 1024,
    parameter int RING_DEPTH    = 16,
    parameter int HIST_HALF     = 16384
) (
    input  logic         clk,
    input  logic         rst_n,
    // Requests.
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata from bit 0: channel[11:0], map_position[16:12], map_colour[18:17],
    // map_segment[22:19], hit_time_ns[70:23], raw_time_nonzero[71],
    // trigger_count[87:72], bin_index[102:88], zero[103]
    input  logic [103:0] s_tdata,
    // tuser: command[1:0]
    input  logic [1:0]   s_tuser,
    // Results.
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata from bit 0: bin_count[31:0], pairs_added[36:32], bad_trigger[37],
    // ring_overflow[38], zero[39]
    output logic [39:0]  m_tdata,
    // Configuration writes.
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_index,
    input  logic [13:0]  cfg_data
);

    localparam int MAW = $clog2(MAP_DEPTH);
    localparam int RW  = $clog2(RING_DEPTH);
    localparam int SW  = $clog2(RING_DEPTH + 1);
    localparam int HW  = $clog2(2 * HIST_HALF);
    localparam logic [SW-1:0] SCAN_END  = SW'(RING_DEPTH);
    localparam logic [SW-1:0] SCAN_LAST = SW'(RING_DEPTH - 1);
    localparam logic [RW-1:0] WP_LAST   = RW'(RING_DEPTH - 1);

    // Request fields.
    logic [11:0] in_channel;
    logic [4:0]  in_position;
    logic [1:0]  in_colour;
    logic [3:0]  in_segment;
    logic [47:0] in_time;
    logic        in_raw_ok;
    logic [15:0] in_trigger;
    logic [14:0] in_bin;

    assign in_channel  = s_tdata[11:0];
    assign in_position = s_tdata[16:12];
    assign in_colour   = s_tdata[18:17];
    assign in_segment  = s_tdata[22:19];
    assign in_time     = s_tdata[70:23];
    assign in_raw_ok   = s_tdata[71];
    assign in_trigger  = s_tdata[87:72];
    assign in_bin      = s_tdata[102:88];

    // Sequencer and control state.
    ctdh_pkg::state_t state_reg, state_next;
    logic [SW-1:0]    scan_reg, scan_next;
    logic [RW-1:0]    wp_reg, wp_next;
    logic [RING_DEPTH-1:0] ring_valid_reg, ring_valid_next;
    logic             err_reg, err_next;
    logic             out_valid_reg, out_valid_next;
    logic [13:0]      window_reg;
    logic [11:0]      low_ch_reg;
    logic [11:0]      high_ch_reg;

    // Captured request and working values.
    logic [11:0] chan_reg, chan_next;
    logic [47:0] time_reg, time_next;
    logic        raw_reg, raw_next;
    logic [15:0] trig_reg, trig_next;
    logic [14:0] bin_reg, bin_next;
    logic [4:0]  npos_reg, npos_next;
    logic [1:0]  ncol_reg, ncol_next;
    logic        n_cc_reg, n_cc_next;
    logic        n_seg_reg, n_seg_next;
    logic [HW-1:0] inc_bin_reg, inc_bin_next;
    logic        ovf_cand_reg, ovf_cand_next;
    logic [31:0] count_reg, count_next;
    logic [4:0]  pairs_reg, pairs_next;
    logic        ovf_reg, ovf_next;
    logic [31:0] out_count_reg, out_count_next;
    logic [4:0]  out_pairs_reg, out_pairs_next;
    logic        out_bad_reg, out_bad_next;
    logic        out_ovf_reg, out_ovf_next;

    // Memories and their read registers.
    ctdh_pkg::map_entry_t  map_mem [MAP_DEPTH];
    ctdh_pkg::map_entry_t  map_rd_reg;
    ctdh_pkg::ring_entry_t ring_mem [RING_DEPTH];
    ctdh_pkg::ring_entry_t ring_rd_reg;
    logic                  map_we;
    logic [MAW-1:0]        map_raddr;
    logic                  ring_we;
    logic [RW-1:0]         ring_raddr;
    ctdh_pkg::ring_entry_t ring_wdata;

    // Histogram memory interface.
    logic [HW-1:0] hist_rd_addr;
    logic          hist_wr_en;
    logic [31:0]   hist_rd_data;
    logic          hist_busy;

    logic accept;
    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ctdh_pkg::ST_IDLE);

    // Channel lookup of the captured hit.
    logic [11:0] ch_offset;
    logic        ch_in_range;
    logic        map_pos_ok;
    logic        lookup_ok;
    assign ch_offset   = chan_reg - low_ch_reg;
    assign ch_in_range = raw_reg && (chan_reg >= low_ch_reg) && (chan_reg <= high_ch_reg)
                         && ({1'b0, ch_offset} < 13'(MAP_DEPTH));
    assign map_pos_ok  = (map_rd_reg.pos != 5'd0)
                         && ({1'b0, map_rd_reg.pos} < 6'(NUM_POSITIONS));
    assign lookup_ok   = ch_in_range && map_pos_ok;
    assign map_raddr   = ch_offset[MAW-1:0];

    // Shared time-difference compare on the ring entry being scanned.
    logic [48:0]   diff;
    logic          p_later;
    logic [47:0]   dt;
    logic          in_window;
    logic          pair_ok;
    logic          match;
    logic [HW-1:0] bin_plus;
    logic [HW-1:0] bin_minus;
    logic          p_valid;
    assign diff      = {1'b0, time_reg} - {1'b0, ring_rd_reg.hit_time};
    assign p_later   = diff[48];
    assign dt        = diff[47:0];
    assign p_valid   = ring_valid_reg[scan_reg[RW-1:0]];
    assign in_window = p_valid && !p_later && (dt <= 48'(window_reg));
    assign pair_ok   = in_window && (dt < 48'(HIST_HALF))
                       && (ring_rd_reg.pos == npos_reg) && (ring_rd_reg.col == ncol_reg);
    assign match     = pair_ok && (ring_rd_reg.is_cc || n_cc_reg);
    assign bin_plus  = HW'(HIST_HALF) + dt[HW-1:0];
    assign bin_minus = HW'(HIST_HALF) - dt[HW-1:0];

    // Ring read address follows the next scan index.
    assign ring_raddr = (scan_next >= SCAN_END) ? '0 : scan_next[RW-1:0];

    // Histogram port selection.
    assign hist_rd_addr = (state_reg == ctdh_pkg::ST_BIN_RD) ? HW'(bin_reg)
                        : (ring_rd_reg.is_cc ? bin_plus : bin_minus);
    assign hist_wr_en   = (state_reg == ctdh_pkg::ST_INC);

    // Map loads are written straight from the accepted request.
    assign map_we = accept && (s_tuser == ctdh_pkg::CMD_LOAD_MAP)
                    && ({1'b0, in_channel} < 13'(MAP_DEPTH));

    assign ring_wdata = '{is_cc: n_cc_reg, pos: npos_reg, col: ncol_reg, hit_time: time_reg};

    // Sequencer: next state and working values.
    always_comb
    begin
        state_next      = state_reg;
        scan_next       = scan_reg;
        wp_next         = wp_reg;
        ring_valid_next = ring_valid_reg;
        err_next        = err_reg;
        out_valid_next  = out_valid_reg;
        chan_next       = chan_reg;
        time_next       = time_reg;
        raw_next        = raw_reg;
        trig_next       = trig_reg;
        bin_next        = bin_reg;
        npos_next       = npos_reg;
        ncol_next       = ncol_reg;
        n_cc_next       = n_cc_reg;
        n_seg_next      = n_seg_reg;
        inc_bin_next    = inc_bin_reg;
        ovf_cand_next   = ovf_cand_reg;
        count_next      = count_reg;
        pairs_next      = pairs_reg;
        ovf_next        = ovf_reg;
        out_count_next  = out_count_reg;
        out_pairs_next  = out_pairs_reg;
        out_bad_next    = out_bad_reg;
        out_ovf_next    = out_ovf_reg;
        ring_we         = 1'b0;

        // The receiver drains the output register.
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ctdh_pkg::ST_CLEAR:
            begin
                if (!hist_busy)
                begin
                    state_next = ctdh_pkg::ST_IDLE;
                end
            end

            ctdh_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    chan_next     = in_channel;
                    time_next     = in_time;
                    raw_next      = in_raw_ok;
                    trig_next     = in_trigger;
                    bin_next      = in_bin;
                    count_next    = '0;
                    pairs_next    = '0;
                    ovf_next      = 1'b0;
                    ovf_cand_next = 1'b0;
                    case (s_tuser)
                        ctdh_pkg::CMD_READ_BIN:
                        begin
                            if (18'(in_bin) < 18'(2 * HIST_HALF))
                            begin
                                state_next = ctdh_pkg::ST_BIN_RD;
                            end
                            else
                            begin
                                state_next = ctdh_pkg::ST_FINISH;
                            end
                        end
                        ctdh_pkg::CMD_HIT:
                        begin
                            state_next = err_reg ? ctdh_pkg::ST_FINISH : ctdh_pkg::ST_MAP_RD;
                        end
                        default:
                        begin
                            state_next = ctdh_pkg::ST_FINISH;
                        end
                    endcase
                end
            end

            // Map read address is presented in this cycle.
            ctdh_pkg::ST_MAP_RD:
            begin
                state_next = ctdh_pkg::ST_MAP_CHK;
            end

            // Classify the hit; the ring read of entry zero starts here.
            ctdh_pkg::ST_MAP_CHK:
            begin
                npos_next  = map_rd_reg.pos;
                ncol_next  = map_rd_reg.col;
                n_cc_next  = lookup_ok && (map_rd_reg.seg == 4'd0);
                n_seg_next = lookup_ok && (map_rd_reg.seg != 4'd0)
                             && ({1'b0, map_rd_reg.seg} < 5'(NUM_SEGMENTS));
                scan_next  = '0;
                state_next = lookup_ok ? ctdh_pkg::ST_SCAN : ctdh_pkg::ST_FINISH;
            end

            // One ring entry per cycle unless a match holds the walk; a match reads its histogram bin.
            ctdh_pkg::ST_SCAN:
            begin
                scan_next = scan_reg + SW'(1);
                if (scan_reg[RW-1:0] == wp_reg)
                begin
                    ovf_cand_next = in_window;
                end
                if (match)
                begin
                    inc_bin_next = hist_rd_addr;
                    if (pairs_reg != ctdh_pkg::PAIRS_MAX)
                    begin
                        pairs_next = pairs_reg + 5'd1;
                    end
                    state_next = ctdh_pkg::ST_INC;
                end
                else if (scan_reg == SCAN_LAST)
                begin
                    state_next = ctdh_pkg::ST_UPDATE;
                end
            end

            // Histogram write-back of the incremented bin.
            ctdh_pkg::ST_INC:
            begin
                state_next = (scan_reg == SCAN_END) ? ctdh_pkg::ST_UPDATE : ctdh_pkg::ST_SCAN;
            end

            // Latch the error or buffer the hit in the ring, or do neither.
            ctdh_pkg::ST_UPDATE:
            begin
                if (n_cc_reg && (trig_reg == 16'd0))
                begin
                    err_next = 1'b1;
                end
                else if (n_cc_reg || n_seg_reg)
                begin
                    ring_we                 = 1'b1;
                    ring_valid_next[wp_reg] = 1'b1;
                    ovf_next                = ovf_cand_reg;
                    wp_next = (wp_reg == WP_LAST) ? '0 : wp_reg + RW'(1);
                end
                state_next = ctdh_pkg::ST_FINISH;
            end

            ctdh_pkg::ST_BIN_RD:
            begin
                state_next = ctdh_pkg::ST_BIN_CAP;
            end

            ctdh_pkg::ST_BIN_CAP:
            begin
                count_next = hist_rd_data;
                state_next = ctdh_pkg::ST_FINISH;
            end

            // Hand the result over once the output register is free.
            ctdh_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_count_next = count_reg;
                    out_pairs_next = pairs_reg;
                    out_bad_next   = err_reg;
                    out_ovf_next   = ovf_reg;
                    state_next     = ctdh_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = ctdh_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ctdh_pkg::ST_CLEAR;
            scan_reg       <= '0;
            wp_reg         <= '0;
            ring_valid_reg <= '0;
            err_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            scan_reg       <= scan_next;
            wp_reg         <= wp_next;
            ring_valid_reg <= ring_valid_next;
            err_reg        <= err_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg  <= ctdh_pkg::WINDOW_RESET;
            low_ch_reg  <= ctdh_pkg::LOW_CH_RESET;
            high_ch_reg <= ctdh_pkg::HIGH_CH_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                ctdh_pkg::REG_WINDOW:  window_reg  <= cfg_data;
                ctdh_pkg::REG_LOW_CH:  low_ch_reg  <= cfg_data[11:0];
                ctdh_pkg::REG_HIGH_CH: high_ch_reg <= cfg_data[11:0];
                default:               window_reg  <= window_reg;
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        chan_reg      <= chan_next;
        time_reg      <= time_next;
        raw_reg       <= raw_next;
        trig_reg      <= trig_next;
        bin_reg       <= bin_next;
        npos_reg      <= npos_next;
        ncol_reg      <= ncol_next;
        n_cc_reg      <= n_cc_next;
        n_seg_reg     <= n_seg_next;
        inc_bin_reg   <= inc_bin_next;
        ovf_cand_reg  <= ovf_cand_next;
        count_reg     <= count_next;
        pairs_reg     <= pairs_next;
        ovf_reg       <= ovf_next;
        out_count_reg <= out_count_next;
        out_pairs_reg <= out_pairs_next;
        out_bad_reg   <= out_bad_next;
        out_ovf_reg   <= out_ovf_next;
    end

    // Channel map memory.
    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            map_mem[in_channel[MAW-1:0]] <= '{pos: in_position, col: in_colour, seg: in_segment};
        end
        map_rd_reg <= map_mem[map_raddr];
    end

    // Ring of recent hits.
    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[wp_reg] <= ring_wdata;
        end
        ring_rd_reg <= ring_mem[ring_raddr];
    end

    ctdh_hist_ram #(
        .HIST_HALF (HIST_HALF)
    ) u_hist (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (hist_rd_addr),
        .wr_en   (hist_wr_en),
        .wr_addr (inc_bin_reg),
        .wr_data (hist_rd_data + 32'd1),
        .rd_data (hist_rd_data),
        .busy    (hist_busy)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_ovf_reg, out_bad_reg, out_pairs_reg, out_count_reg};

endmodule

// ===== src/ctdh_hist_ram.sv =====
`timescale 1ns / 1ps

module ctdh_hist_ram #(
    parameter int HIST_HALF = 16384
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [$clog2(2*HIST_HALF)-1:0] rd_addr,
    input  logic                           wr_en,
    input  logic [$clog2(2*HIST_HALF)-1:0] wr_addr,
    input  logic [31:0]                    wr_data,
    output logic [31:0]                    rd_data,
    output logic                           busy
);

    localparam int DEPTH = 2 * HIST_HALF;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    logic [31:0]   mem [DEPTH];
    logic [31:0]   rd_data_reg;
    logic [AW-1:0] clr_addr_reg;
    logic [AW-1:0] clr_addr_next;
    logic          busy_reg;
    logic          busy_next;

    // The clearing sweep walks every bin once after reset.
    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        busy_next     = busy_reg;
        if (busy_reg)
        begin
            clr_addr_next = clr_addr_reg + AW'(1);
            if (clr_addr_reg == LAST_ADDR)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            busy_reg     <= 1'b1;
        end
        else
        begin
            clr_addr_reg <= clr_addr_next;
            busy_reg     <= busy_next;
        end
    end

    // Single write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
    assign busy    = busy_reg;

endmodule

// ===== test/coincidence_time_difference_histogram_unit_tb.sv =====
`timescale 1ns / 1ps

module coincidence_time_difference_histogram_unit_tb;

    localparam int NUM_POSITIONS = 17;
    localparam int NUM_SEGMENTS  = 9;
    localparam int MAP_DEPTH     = 1024;
    localparam int RING_DEPTH    = 16;
    localparam int HIST_HALF     = 16384;

    // Slowest run: histogram sweep plus every request at its longest gap,
    // longest hit walk and longest receiver stall, taken several times over.
    localparam int CYCLE_LIMIT   = 800000;
    localparam int SETTLE_CYCLES = 8;

    // Request kind that the unit does not use.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // One request, packed in tdata order from the top bit down.
    typedef struct packed {
        logic [14:0] bin_index;
        logic [15:0] trigger_count;
        logic        raw_time_nonzero;
        logic [47:0] hit_time_ns;
        logic [3:0]  map_segment;
        logic [1:0]  map_colour;
        logic [4:0]  map_position;
        logic [11:0] channel;
    } request_t;

    // One result, packed in tdata order from the top bit down.
    typedef struct packed {
        logic        ring_overflow;
        logic        bad_trigger;
        logic [4:0]  pairs_added;
        logic [31:0] bin_count;
    } outcome_t;

    // One buffered hit of the predictor.
    typedef struct {
        bit          valid;
        bit          is_cc;
        logic [4:0]  pos;
        logic [1:0]  col;
        logic [47:0] hit_time;
    } buffered_hit_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [103:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [39:0]  m_tdata;
    logic         cfg_wr_en;
    logic [1:0]   cfg_index;
    logic [13:0]  cfg_data;

    // Predictor copy of the unit's state and registers.
    ctdh_pkg::map_entry_t map_mem [MAP_DEPTH];
    bit            map_written [MAP_DEPTH];
    int            written_offsets[$];
    buffered_hit_t ring_mem [RING_DEPTH];
    int            ring_ptr;
    int unsigned   hist_mem [2 * HIST_HALF];
    bit            error_flag;
    logic [13:0]   window_reg;
    logic [11:0]   low_reg;
    logic [11:0]   high_reg;

    // Expected results in request order, and bins worth reading back.
    outcome_t      expected_outcomes[$];
    int            touched_bins[$];

    outcome_t      got_outcome;
    outcome_t      want_outcome;
    int            fail_count = 0;
    int            cycle_count = 0;
    int            ready_wait = 0;
    bit            burst_mode;
    int            step_max;
    logic [47:0]   now_t;

    coincidence_time_difference_histogram_unit #(
        .NUM_POSITIONS(NUM_POSITIONS),
        .NUM_SEGMENTS (NUM_SEGMENTS),
        .MAP_DEPTH    (MAP_DEPTH),
        .RING_DEPTH   (RING_DEPTH),
        .HIST_HALF    (HIST_HALF)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // Clock generation.
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Map lookup of a hit channel; true when the channel is valid.
    function automatic bit lookup_channel(input logic [11:0] ch, input logic raw_ok,
                                          output ctdh_pkg::map_entry_t e);
        logic [11:0] off;
        e = '0;
        if (!raw_ok || ch < low_reg || ch > high_reg)
        begin
            return 1'b0;
        end
        off = ch - low_reg;
        if (off >= MAP_DEPTH)
        begin
            return 1'b0;
        end
        e = map_mem[off];
        return (e.pos > 0) && (e.pos < NUM_POSITIONS);
    endfunction

    // Steers a hit away from map entries that were never written.
    function automatic logic [11:0] safe_channel(input logic [11:0] ch);
        logic [11:0] off;
        off = ch - low_reg;
        if (ch >= low_reg && ch <= high_reg && off < MAP_DEPTH && !map_written[off]
            && written_offsets.size() > 0)
        begin
            return low_reg + 12'(written_offsets[$urandom_range(0, written_offsets.size() - 1)]);
        end
        return ch;
    endfunction

    // Updates the predicted state for one request and returns its result.
    function automatic outcome_t compute_histogram_result(input logic [1:0] cmd,
                                                          input request_t r);
        outcome_t             res;
        ctdh_pkg::map_entry_t e;
        bit                   ok;
        bit                   n_cc;
        bit                   n_seg;
        logic [47:0]          dt;
        int                   pairs;
        int                   b;
        int                   i;
        res = '0;
        pairs = 0;
        case (cmd)
            ctdh_pkg::CMD_LOAD_MAP:
            begin
                if (r.channel < MAP_DEPTH)
                begin
                    map_mem[r.channel] = '{pos: r.map_position, col: r.map_colour,
                                           seg: r.map_segment};
                    if (!map_written[r.channel])
                    begin
                        map_written[r.channel] = 1'b1;
                        written_offsets.push_back(int'(r.channel));
                    end
                end
            end
            ctdh_pkg::CMD_READ_BIN:
            begin
                res.bin_count = hist_mem[r.bin_index];
            end
            ctdh_pkg::CMD_HIT:
            begin
                if (!error_flag)
                begin
                    ok = lookup_channel(r.channel, r.raw_time_nonzero, e);
                    n_cc = ok && e.seg == 0;
                    n_seg = ok && e.seg >= 1 && e.seg < NUM_SEGMENTS;
                    // Pair the new hit with each matching buffered hit in the window.
                    if (ok)
                    begin
                        for (i = 0; i < RING_DEPTH; i++)
                        begin
                            if (!ring_mem[i].valid || ring_mem[i].hit_time > r.hit_time_ns)
                                continue;
                            dt = r.hit_time_ns - ring_mem[i].hit_time;
                            if (dt > window_reg || dt >= HIST_HALF)
                                continue;
                            if (ring_mem[i].pos != e.pos || ring_mem[i].col != e.col)
                                continue;
                            if (ring_mem[i].is_cc)
                                b = HIST_HALF + int'(dt);
                            else if (n_cc)
                                b = HIST_HALF - int'(dt);
                            else
                                continue;
                            hist_mem[b] = hist_mem[b] + 1;
                            pairs++;
                            touched_bins.push_back(b);
                            if (touched_bins.size() > 64)
                                void'(touched_bins.pop_front());
                        end
                    end
                    // A central contact without a trigger latches the error.
                    if (n_cc && r.trigger_count == 0)
                    begin
                        error_flag = 1'b1;
                    end
                    else if (n_cc || n_seg)
                    begin
                        if (ring_mem[ring_ptr].valid && ring_mem[ring_ptr].hit_time <= r.hit_time_ns
                            && r.hit_time_ns - ring_mem[ring_ptr].hit_time <= window_reg)
                            res.ring_overflow = 1'b1;
                        ring_mem[ring_ptr] = '{valid: 1'b1, is_cc: n_cc, pos: e.pos, col: e.col,
                                               hit_time: r.hit_time_ns};
                        ring_ptr = (ring_ptr + 1 >= RING_DEPTH) ? 0 : ring_ptr + 1;
                    end
                    res.pairs_added = (pairs > 31) ? 5'd31 : 5'(pairs);
                end
            end
            default:
            begin
            end
        endcase
        res.bad_trigger = error_flag;
        return res;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    // Receiver: stalls at random and checks each result against the oldest expectation.
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
        begin
            got_outcome = m_tdata[38:0];
            if (expected_outcomes.size() == 0)
            begin
                $display("%0t: result mismatch: expected none, actual %h", $time, m_tdata);
                fail_count++;
            end
            else
            begin
                want_outcome = expected_outcomes.pop_front();
                check_field("bin_count", want_outcome.bin_count, got_outcome.bin_count);
                check_field("pairs_added", 32'(want_outcome.pairs_added),
                            32'(got_outcome.pairs_added));
                check_field("bad_trigger", 32'(want_outcome.bad_trigger),
                            32'(got_outcome.bad_trigger));
                check_field("ring_overflow", 32'(want_outcome.ring_overflow),
                            32'(got_outcome.ring_overflow));
            end
            ready_wait = burst_mode ? 0 : $urandom_range(0, 9);
            m_tready <= (ready_wait == 0);
        end
        else if (!m_tready)
        begin
            if (ready_wait > 0)
                ready_wait--;
            if (ready_wait == 0)
                m_tready <= 1'b1;
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("coincidence_time_difference_histogram_unit verification failed");
            $finish;
        end
    end

    // A request with every field random.
    function automatic request_t random_request();
        logic [127:0] bits;
        bits = {$urandom, $urandom, $urandom, $urandom};
        return bits[102:0];
    endfunction

    // Sends one request after a random gap and records its expected result.
    // tvalid stays high on return, so back-to-back requests need no extra edge.
    task automatic send_request(input logic [1:0] cmd, input request_t r);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {1'b0, r};
        do
            @(posedge clk);
        while (!s_tready);
        expected_outcomes.push_back(compute_histogram_result(cmd, r));
    endtask

    task automatic load_map(input logic [11:0] off, input logic [4:0] pos,
                            input logic [1:0] col, input logic [3:0] seg);
        request_t r;
        r = random_request();
        r.channel = off;
        r.map_position = pos;
        r.map_colour = col;
        r.map_segment = seg;
        send_request(ctdh_pkg::CMD_LOAD_MAP, r);
    endtask

    task automatic send_hit(input logic [11:0] ch, input logic [47:0] t, input logic raw_ok,
                            input logic [15:0] trig);
        request_t r;
        r = random_request();
        r.channel = safe_channel(ch);
        r.hit_time_ns = t;
        r.raw_time_nonzero = raw_ok;
        r.trigger_count = trig;
        send_request(ctdh_pkg::CMD_HIT, r);
    endtask

    task automatic read_bin(input logic [14:0] bin);
        request_t r;
        r = random_request();
        r.bin_index = bin;
        send_request(ctdh_pkg::CMD_READ_BIN, r);
    endtask

    // Holds requests back until every expected result has come, then settles.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_outcomes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes all three registers while the unit is idle.
    task automatic write_config(input logic [13:0] win, input logic [11:0] lo,
                                input logic [11:0] hi);
        drain_results();
        cfg_wr_en <= 1'b1;
        cfg_index <= ctdh_pkg::REG_WINDOW;
        cfg_data  <= win;
        @(posedge clk);
        cfg_index <= ctdh_pkg::REG_LOW_CH;
        cfg_data  <= {2'b00, lo};
        @(posedge clk);
        cfg_index <= ctdh_pkg::REG_HIGH_CH;
        cfg_data  <= {2'b00, hi};
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        window_reg = win;
        low_reg = lo;
        high_reg = hi;
    endtask

    // A hit mostly on the densely mapped channels, with time mostly moving forward.
    task automatic random_hit();
        logic [11:0]          ch;
        logic [15:0]          trig;
        logic [63:0]          wide;
        logic                 raw_ok;
        ctdh_pkg::map_entry_t e;
        int                   sel;
        sel = $urandom_range(0, 99);
        if (sel < 70)
            ch = low_reg + 12'($urandom_range(0, 7));
        else if (sel < 90)
            ch = low_reg + 12'($urandom_range(0, 63));
        else
            ch = 12'($urandom);
        ch = safe_channel(ch);
        sel = $urandom_range(0, 99);
        if (sel < 1)
        begin
            wide = {$urandom, $urandom};
            now_t = wide[47:0];
        end
        else if (sel < 4)
            now_t = now_t - 48'($urandom_range(1, 100));
        else
            now_t = now_t + 48'($urandom_range(0, step_max));
        raw_ok = ($urandom_range(0, 19) != 0);
        trig = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom);
        // The error latch is kept for the last test.
        if (trig == 0 && lookup_channel(ch, raw_ok, e) && e.seg == 0)
            trig = 16'd1;
        send_hit(ch, now_t, raw_ok, trig);
    endtask

    // A map load mostly into the dense region with two positions and two colours.
    task automatic random_load();
        logic [11:0] off;
        logic [4:0]  pos;
        logic [1:0]  col;
        logic [3:0]  seg;
        int          sel;
        sel = $urandom_range(0, 99);
        if (sel < 85)
        begin
            off = (sel < 60) ? 12'($urandom_range(0, 7)) : 12'($urandom_range(0, 63));
            pos = 5'($urandom_range(1, 2));
            col = 2'($urandom_range(0, 1));
            seg = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(1, NUM_SEGMENTS - 1));
            if ($urandom_range(0, 9) == 0)
                seg = 4'($urandom);
        end
        else
        begin
            off = 12'($urandom);
            pos = 5'($urandom);
            col = 2'($urandom);
            seg = 4'($urandom);
        end
        load_map(off, pos, col, seg);
    endtask

    // Reads mostly bins that hits have touched.
    task automatic random_read();
        if (touched_bins.size() > 0 && $urandom_range(0, 9) < 7)
            read_bin(15'(touched_bins[$urandom_range(0, touched_bins.size() - 1)]));
        else
            read_bin(15'($urandom));
    endtask

    // One setting of the registers with a mix of hits, loads, reads and noise.
    task automatic run_random_phase(input int count, input logic [13:0] win,
                                    input logic [11:0] lo, input logic [11:0] hi,
                                    input int step);
        int n;
        int sel;
        write_config(win, lo, hi);
        step_max = step;
        for (n = 0; n < count; n++)
        begin
            burst_mode = (n < 40);
            sel = $urandom_range(0, 99);
            if (sel < 55)
                random_hit();
            else if (sel < 70)
                random_load();
            else if (sel < 88)
                random_read();
            else if (sel < 94)
                send_request(CMD_UNUSED, random_request());
            else
                send_hit(12'($urandom), now_t, 1'b0, 16'($urandom));
        end
        burst_mode = 1'b0;
    endtask

    // Histogram is clear after reset; the unused kind has no effect.
    task automatic test_reset_state();
        read_bin(15'd0);
        read_bin(15'(HIST_HALF));
        read_bin(15'h7FFF);
        send_request(CMD_UNUSED, random_request());
    endtask

    // Map entries at the extremes of their fields, and a load beyond the map.
    task automatic test_map_load();
        load_map(12'd0, 5'd1, 2'd0, 4'd0);
        load_map(12'd1, 5'd1, 2'd0, 4'd1);
        load_map(12'd2, 5'(NUM_POSITIONS - 1), 2'd3, 4'(NUM_SEGMENTS - 1));
        load_map(12'd3, 5'(NUM_POSITIONS - 1), 2'd3, 4'd0);
        // Position zero and positions past the last one are invalid.
        load_map(12'd4, 5'd0, 2'd2, 4'd3);
        load_map(12'd5, 5'd31, 2'd1, 4'd15);
        load_map(12'd7, 5'(NUM_POSITIONS), 2'd0, 4'd0);
        // Valid channel whose segment is neither a central contact nor a segment.
        load_map(12'd6, 5'd1, 2'd0, 4'd15);
        load_map(12'(MAP_DEPTH - 1), 5'd2, 2'd1, 4'd0);
        load_map(12'hFFF, 5'd1, 2'd0, 4'd0);
    endtask

    // Both pair directions, the window edge, invalid hits and time going backwards.
    task automatic test_hit_pairing();
        send_hit(12'd1, 48'd1000, 1'b1, 16'd5);
        send_hit(12'd0, 48'd1000, 1'b1, 16'd7);
        send_hit(12'd1, 48'd1010, 1'b1, 16'd0);
        send_hit(12'd6, 48'd1020, 1'b1, 16'd9);
        send_hit(12'd4, 48'd1020, 1'b1, 16'd9);
        send_hit(12'd0, 48'd1030, 1'b0, 16'd9);
        send_hit(12'd2, 48'd1040, 1'b1, 16'd1);
        send_hit(12'd3, 48'd1050, 1'b1, 16'd1);
        send_hit(12'd0, 48'd900, 1'b1, 16'd3);
        send_hit(12'd0, 48'd100000, 1'b1, 16'd2);
        send_hit(12'd1, 48'd116383, 1'b1, 16'd2);
        send_hit(12'd1, 48'd116384, 1'b1, 16'd2);
        read_bin(15'(HIST_HALF));
        read_bin(15'h7FFF);
        now_t = 48'd200000;
    endtask

    // Several register settings, the extremes among them.
    task automatic test_random_traffic();
        run_random_phase(270, ctdh_pkg::WINDOW_RESET, ctdh_pkg::LOW_CH_RESET,
                         ctdh_pkg::HIGH_CH_RESET, 300);
        run_random_phase(270, 14'd50, 12'd0, 12'd1023, 20);
        run_random_phase(270, 14'd0, 12'd0, 12'd1023, 2);
        run_random_phase(270, 14'($urandom_range(100, 2000)), 12'd3, 12'd40, 150);
        run_random_phase(270, 14'h3FFF, 12'd0, 12'hFFF, 1500);
        run_random_phase(200, 14'd800, 12'hFFF, 12'hFFF, 100);
        run_random_phase(200, 14'd200, 12'd0, 12'd0, 40);
        run_random_phase(100, 14'd300, 12'd20, 12'd10, 50);
    endtask

    // A central contact without a trigger pairs, then latches the error for good.
    task automatic test_bad_trigger();
        write_config(ctdh_pkg::WINDOW_RESET, ctdh_pkg::LOW_CH_RESET, ctdh_pkg::HIGH_CH_RESET);
        load_map(12'd0, 5'd1, 2'd0, 4'd0);
        load_map(12'd1, 5'd1, 2'd0, 4'd1);
        now_t = now_t + 48'd20000;
        send_hit(12'd1, now_t, 1'b1, 16'd4);
        send_hit(12'd0, now_t + 48'd3, 1'b1, 16'd0);
        send_hit(12'd1, now_t + 48'd5, 1'b1, 16'd4);
        load_map(12'd2, 5'd2, 2'd2, 4'd2);
        read_bin(15'(HIST_HALF - 3));
        send_request(CMD_UNUSED, random_request());
    endtask

    // Main sequence.
    initial
    begin
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = ctdh_pkg::CMD_LOAD_MAP;
        m_tready   = 1'b0;
        cfg_wr_en  = 1'b0;
        cfg_index  = ctdh_pkg::REG_WINDOW;
        cfg_data   = '0;
        burst_mode = 1'b0;
        step_max   = 100;
        now_t      = '0;
        ring_ptr   = 0;
        error_flag = 1'b0;
        window_reg = ctdh_pkg::WINDOW_RESET;
        low_reg    = ctdh_pkg::LOW_CH_RESET;
        high_reg   = ctdh_pkg::HIGH_CH_RESET;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_map_load();
        test_hit_pairing();
        test_random_traffic();
        test_bad_trigger();

        drain_results();
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("coincidence_time_difference_histogram_unit verification clean");
        else
            $display("coincidence_time_difference_histogram_unit verification failed");
        $finish;
    end

endmodule
